// File: sv/htsu_pkg.sv
// ----------------------------------------------------------------------------
// htsu_pkg
// types, codes and result tables shared by the homing/trial sequencer
// ----------------------------------------------------------------------------
package htsu_pkg;

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // stream widths
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIAL_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOMING_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 2'd2;

  // register reset values
  localparam logic [7:0]  TRIAL_SPEED_RST  = 8'd168;
  localparam logic [7:0]  HOMING_SPEED_RST = 8'd5;
  localparam logic [15:0] DEBOUNCE_MS_RST  = 16'd50;

  // host command codes
  localparam logic [2:0] ACT_START  = 3'd0;
  localparam logic [2:0] ACT_POLL   = 3'd1;
  localparam logic [2:0] ACT_CHECK  = 3'd2;
  localparam logic [2:0] ACT_END    = 3'd3;
  localparam logic [2:0] ACT_ESTOP  = 3'd4;

  // motor link bytes
  localparam logic [7:0] LINK_SYNC       = 8'h00;
  localparam logic [7:0] LINK_SET_SPEED  = 8'h31;
  localparam logic [7:0] LINK_RESET_ENC  = 8'h35;
  localparam logic [7:0] LINK_STOP_SPEED = 8'd128;

  // lengths of the result runs
  localparam logic [3:0] LEN_HOMED      = 4'd9;
  localparam logic [3:0] LEN_TRIAL_DONE = 4'd4;
  localparam logic [3:0] LEN_SPEED      = 4'd3;
  localparam logic [3:0] LEN_REPORT     = 4'd1;
  localparam logic [3:0] LEN_NONE       = 4'd0;

  typedef enum logic [1:0] {
    MODE_HWTEST = 2'd0,
    MODE_IDLE   = 2'd1,
    MODE_HOMING = 2'd2,
    MODE_TRIAL  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_MOTOR      = 3'd0,
    KIND_HOMED      = 3'd1,
    KIND_TRIAL_DONE = 3'd2,
    KIND_SAMPLE     = 3'd3,
    KIND_SWITCHES   = 3'd4,
    KIND_READY      = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_SAMPLE   = 3'd2,
    CMD_SWITCHES = 3'd3,
    CMD_READY    = 3'd4,
    CMD_ESTOP    = 3'd5
  } cmd_t;

  // one classified pass, as handed from front to back
  typedef struct packed {
    logic               homed;
    logic               trial_done;
    cmd_t               cmd;
    logic [7:0]         speed;
    logic signed [24:0] sample;
    logic               home_pressed;
    logic               end_pressed;
  } job_t;

  // one result request
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         motor_byte;
    logic signed [24:0] sample_value;
    logic               home_pressed;
    logic               end_pressed;
  } item_t;

  function automatic logic [3:0] seg_len_a(input job_t j);
    if (j.homed) begin
      return LEN_HOMED;
    end else if (j.trial_done) begin
      return LEN_TRIAL_DONE;
    end
    return LEN_NONE;
  endfunction

  function automatic logic [3:0] seg_len_b(input job_t j);
    logic [3:0] len;
    unique case (j.cmd)
      CMD_START, CMD_ESTOP: len = LEN_SPEED;
      CMD_SAMPLE, CMD_SWITCHES, CMD_READY: len = LEN_REPORT;
      default: len = LEN_NONE;
    endcase
    return len;
  endfunction

  // result number idx of a job: mode run first, then the command run
  function automatic item_t job_item(input job_t j, input logic [3:0] idx);
    item_t      it;
    logic [3:0] len_a;
    logic [3:0] pos;
    it.kind         = KIND_MOTOR;
    it.motor_byte   = LINK_SYNC;
    it.sample_value = '0;
    it.home_pressed = 1'b0;
    it.end_pressed  = 1'b0;
    len_a = seg_len_a(j);
    if (idx < len_a) begin
      pos = idx;
      if (j.homed) begin
        // stop, encoder reset, trial speed, then the homed report
        unique case (pos)
          4'd0, 4'd3, 4'd5: it.motor_byte = LINK_SYNC;
          4'd1, 4'd6:       it.motor_byte = LINK_SET_SPEED;
          4'd2:             it.motor_byte = LINK_STOP_SPEED;
          4'd4:             it.motor_byte = LINK_RESET_ENC;
          4'd7:             it.motor_byte = j.speed;
          default: begin
            it.kind       = KIND_HOMED;
            it.motor_byte = '0;
          end
        endcase
      end else begin
        unique case (pos)
          4'd0: it.motor_byte = LINK_SYNC;
          4'd1: it.motor_byte = LINK_SET_SPEED;
          4'd2: it.motor_byte = LINK_STOP_SPEED;
          default: begin
            it.kind       = KIND_TRIAL_DONE;
            it.motor_byte = '0;
          end
        endcase
      end
    end else begin
      pos = idx - len_a;
      unique case (j.cmd)
        CMD_START, CMD_ESTOP: begin
          unique case (pos)
            4'd0: it.motor_byte = LINK_SYNC;
            4'd1: it.motor_byte = LINK_SET_SPEED;
            default: it.motor_byte = (j.cmd == CMD_START) ? j.speed : LINK_STOP_SPEED;
          endcase
        end
        CMD_SAMPLE: begin
          it.kind         = KIND_SAMPLE;
          it.motor_byte   = '0;
          it.sample_value = j.sample;
        end
        CMD_SWITCHES: begin
          it.kind         = KIND_SWITCHES;
          it.motor_byte   = '0;
          it.home_pressed = j.home_pressed;
          it.end_pressed  = j.end_pressed;
        end
        CMD_READY: begin
          it.kind       = KIND_READY;
          it.motor_byte = '0;
        end
        default: it.motor_byte = '0;
      endcase
    end
    return it;
  endfunction

endpackage

// File: sv/htsu_front.sv
// ----------------------------------------------------------------------------
// htsu_front
// takes passes, runs mode and debounce state, classifies each pass into a job
// ----------------------------------------------------------------------------
module htsu_front
  import htsu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_ready,
  output logic                  q_push,
  output job_t                  q_job
);

  logic [7:0]  trial_speed_r;
  logic [7:0]  homing_speed_r;
  logic [15:0] debounce_ms_r;
  mode_t       mode_r, mode_nxt, mode_mid;
  logic        prev_r, prev_nxt;
  logic        stable_r, stable_nxt;
  logic [31:0] change_time_r, change_time_nxt;
  logic [31:0] elapsed;
  logic        homed, trial_done;
  cmd_t        cmd;
  logic        accept;

  logic [31:0]        now_ms;
  logic               home_lvl;
  logic               end_lvl;
  logic signed [24:0] load_sample;
  logic               has_command;
  logic [2:0]         action;

  assign now_ms      = in_tdata[31:0];
  assign home_lvl    = in_tdata[32];
  assign end_lvl     = in_tdata[33];
  assign load_sample = in_tdata[58:34];
  assign has_command = in_tuser[0];
  assign action      = in_tuser[3:1];

  assign in_tready = q_ready;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  // next state: mode action first, then the host command
  always_comb begin
    mode_mid        = mode_r;
    homed           = 1'b0;
    trial_done      = 1'b0;
    prev_nxt        = prev_r;
    stable_nxt      = stable_r;
    change_time_nxt = change_time_r;
    elapsed         = now_ms - change_time_r;
    unique case (mode_r)
      MODE_HOMING: begin
        if (home_lvl != prev_r) begin
          change_time_nxt = now_ms;
        end
        elapsed = now_ms - change_time_nxt;
        if (elapsed > {16'd0, debounce_ms_r} && home_lvl != stable_r) begin
          stable_nxt = home_lvl;
          if (!home_lvl) begin
            homed    = 1'b1;
            mode_mid = MODE_TRIAL;
          end
        end
        prev_nxt = home_lvl;
      end
      MODE_TRIAL: begin
        if (!end_lvl) begin
          trial_done = 1'b1;
          mode_mid   = MODE_IDLE;
        end
      end
      default: ;
    endcase

    cmd      = CMD_NONE;
    mode_nxt = mode_mid;
    if (has_command) begin
      unique case (action)
        ACT_START: begin
          if (mode_mid == MODE_IDLE) begin
            cmd        = CMD_START;
            mode_nxt   = MODE_HOMING;
            prev_nxt   = home_lvl;
            stable_nxt = home_lvl;
          end
        end
        ACT_POLL: begin
          if (mode_mid == MODE_TRIAL) begin
            cmd = CMD_SAMPLE;
          end
        end
        ACT_CHECK: begin
          if (mode_mid == MODE_HWTEST) begin
            cmd = CMD_SWITCHES;
          end
        end
        ACT_END: begin
          if (mode_mid == MODE_HWTEST) begin
            cmd      = CMD_READY;
            mode_nxt = MODE_IDLE;
          end
        end
        ACT_ESTOP: begin
          cmd = CMD_ESTOP;
          if (mode_mid != MODE_HWTEST) begin
            mode_nxt = MODE_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // job to the queue
  always_comb begin
    q_job.homed        = homed;
    q_job.trial_done   = trial_done;
    q_job.cmd          = cmd;
    q_job.speed        = homed ? trial_speed_r : homing_speed_r;
    q_job.sample       = load_sample;
    q_job.home_pressed = ~home_lvl;
    q_job.end_pressed  = ~end_lvl;
    q_push             = accept && (homed || trial_done || cmd != CMD_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_HWTEST;
      prev_r        <= 1'b1;
      stable_r      <= 1'b1;
      change_time_r <= '0;
    end else if (accept) begin
      mode_r        <= mode_nxt;
      prev_r        <= prev_nxt;
      stable_r      <= stable_nxt;
      change_time_r <= change_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trial_speed_r  <= TRIAL_SPEED_RST;
      homing_speed_r <= HOMING_SPEED_RST;
      debounce_ms_r  <= DEBOUNCE_MS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRIAL_SPEED:  trial_speed_r  <= cfg_data[7:0];
        REG_HOMING_SPEED: homing_speed_r <= cfg_data[7:0];
        REG_DEBOUNCE_MS:  debounce_ms_r  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/htsu_queue.sv
// ----------------------------------------------------------------------------
// htsu_queue
// small job queue between front and back
// ----------------------------------------------------------------------------
module htsu_queue
  import htsu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic ready,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready      = count_r != CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: sv/htsu_back.sv
// ----------------------------------------------------------------------------
// htsu_back
// turns the head job into registered result requests, one per cycle unless stalled
// ----------------------------------------------------------------------------
module htsu_back
  import htsu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  job_t                  head_job,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  logic [3:0] idx_r, idx_nxt;
  logic [3:0] total;
  logic       is_last;
  logic       advance;
  item_t      item;
  item_t      out_item_r;
  logic       out_last_r;
  logic       out_valid_r, out_valid_nxt;

  assign item    = job_item(head_job, idx_r);
  assign total   = seg_len_a(head_job) + seg_len_b(head_job);
  assign is_last = idx_r == total - 4'd1;
  assign advance = head_valid && (!out_valid_r || out_tready);
  assign pop     = advance && is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (advance) begin
      idx_nxt = is_last ? 4'd0 : idx_r + 4'd1;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= item;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_item_r.end_pressed, out_item_r.home_pressed,
                       out_item_r.sample_value, out_item_r.motor_byte};
  assign out_tuser  = out_item_r.kind;
  assign out_tlast  = out_last_r;

endmodule

// File: sv/homing_trial_sequencer_unit.sv
// ----------------------------------------------------------------------------
// homing_trial_sequencer_unit
// mode sequencer for a homing and trial rig: motor link bytes and host reports
// ----------------------------------------------------------------------------
// Each input request is one controller pass. The front end takes a pass in
// every cycle the job queue has room, runs the mode (hardware test, idle,
// homing, trial) and the home switch debounce on wrapping 32-bit millisecond
// time, and turns the pass into at most one queued job. The back end expands
// the head job into result requests at one per cycle, while the receiver is
// ready, through an output register. A pass has 0 to 12 results, 12 at most when
// homing completes and an emergency stop arrives in the same pass. Passes that
// cause no result never occupy the queue. Configuration writes are taken in any
// cycle (cfg_ready is tied high) and are meant to happen while the block is
// idle; an index beyond the register list is accepted and ignored.
// ----------------------------------------------------------------------------
module homing_trial_sequencer_unit
  import htsu_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH_DEF  // job queue depth, 1 to 32
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // pass input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] now_ms, [32] home_switch_level, [33] end_switch_level,
  // [58:34] load_sample, [63:59] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] has_command, [3:1] action
  input  logic [IN_USER_W-1:0]  in_tuser,
  // result output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] motor_byte, [32:8] sample_value, [33] home_pressed,
  // [34] end_pressed, [39:35] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [2:0] kind
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast,
  // register writes: 0 trial_speed, 1 homing_speed, 2 debounce_ms
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // front to queue
  logic q_ready;
  logic q_push;
  job_t q_job;

  // queue to back
  logic head_valid;
  job_t head_job;
  logic q_pop;

  // classification and mode state
  htsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // lets the front keep taking passes while results drain
  htsu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // result expansion, one request per cycle unless the receiver stalls
  htsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: sv/htsu_checker.sv
// ----------------------------------------------------------------------------
// htsu_port_checks
// port-level checks on the result stream of the sequencer
// ----------------------------------------------------------------------------
module htsu_port_checks
  import htsu_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // report kinds always close their pass
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SAMPLE || out_tuser == KIND_SWITCHES ||
                   out_tuser == KIND_READY) |-> out_tlast)
    else $error("report not marked last");

  // motor byte only on motor requests
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_MOTOR |-> out_tdata[7:0] == 8'd0)
    else $error("motor byte on a report");

  // sample only on sample reports
  a_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_SAMPLE |-> out_tdata[32:8] == 25'd0)
    else $error("sample value outside a sample report");

endmodule

bind homing_trial_sequencer_unit htsu_port_checks u_htsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: sim/htsu_checker.sv
// ----------------------------------------------------------------------------
// htsu_checker
// watches the sequencer's streams, keeps its own copy of the mode machine and
// compares every result request with the bytes and reports that are due
// ----------------------------------------------------------------------------
module htsu_checker
  import htsu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_due,
  output int                    results_seen
);

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         motor_byte;
    logic signed [24:0] sample_value;
    logic               home_pressed;
    logic               end_pressed;
    logic               last;
  } link_item_t;

  link_item_t due_items[$];
  link_item_t pass_items[$];

  logic [7:0]  trial_speed;
  logic [7:0]  homing_speed;
  logic [15:0] debounce_ms;
  mode_t       mode;
  logic        prev_home;
  logic        stable_home;
  logic [31:0] change_time;

  task automatic emit_item(input kind_t k, input logic [7:0] b,
                           input logic signed [24:0] load, input logic hp,
                           input logic ep);
    link_item_t it;
    it.kind         = k;
    it.motor_byte   = b;
    it.sample_value = load;
    it.home_pressed = hp;
    it.end_pressed  = ep;
    it.last         = 1'b0;
    pass_items.push_back(it);
  endtask

  task automatic emit_speed(input logic [7:0] speed);
    emit_item(KIND_MOTOR, LINK_SYNC, '0, 1'b0, 1'b0);
    emit_item(KIND_MOTOR, LINK_SET_SPEED, '0, 1'b0, 1'b0);
    emit_item(KIND_MOTOR, speed, '0, 1'b0, 1'b0);
  endtask

  // mode action first, then the host command
  task automatic sequence_pass(input logic [31:0] now, input logic home,
                               input logic endl, input logic has_cmd,
                               input logic [2:0] act,
                               input logic signed [24:0] load);
    logic [31:0] elapsed;
    pass_items.delete();
    if (mode == MODE_HOMING) begin
      if (home != prev_home) change_time = now;
      elapsed = now - change_time;
      if (elapsed > {16'd0, debounce_ms} && home != stable_home) begin
        stable_home = home;
        if (!home) begin
          emit_speed(LINK_STOP_SPEED);
          emit_item(KIND_MOTOR, LINK_SYNC, '0, 1'b0, 1'b0);
          emit_item(KIND_MOTOR, LINK_RESET_ENC, '0, 1'b0, 1'b0);
          emit_speed(trial_speed);
          mode = MODE_TRIAL;
          emit_item(KIND_HOMED, 8'd0, '0, 1'b0, 1'b0);
        end
      end
      prev_home = home;
    end else if (mode == MODE_TRIAL && !endl) begin
      emit_speed(LINK_STOP_SPEED);
      mode = MODE_IDLE;
      emit_item(KIND_TRIAL_DONE, 8'd0, '0, 1'b0, 1'b0);
    end
    if (has_cmd) begin
      case (act)
        ACT_START: if (mode == MODE_IDLE) begin
          emit_speed(homing_speed);
          mode        = MODE_HOMING;
          prev_home   = home;
          stable_home = home;
        end
        ACT_POLL: if (mode == MODE_TRIAL) emit_item(KIND_SAMPLE, 8'd0, load, 1'b0, 1'b0);
        ACT_CHECK: if (mode == MODE_HWTEST) emit_item(KIND_SWITCHES, 8'd0, '0, !home, !endl);
        ACT_END: if (mode == MODE_HWTEST) begin
          mode = MODE_IDLE;
          emit_item(KIND_READY, 8'd0, '0, 1'b0, 1'b0);
        end
        ACT_ESTOP: begin
          emit_speed(LINK_STOP_SPEED);
          if (mode != MODE_HWTEST) mode = MODE_IDLE;
        end
        default: ;
      endcase
    end
    if (pass_items.size() > 0) pass_items[pass_items.size() - 1].last = 1'b1;
    foreach (pass_items[i]) due_items.push_back(pass_items[i]);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    link_item_t want;
    if (!rst_n) begin
      trial_speed  = TRIAL_SPEED_RST;
      homing_speed = HOMING_SPEED_RST;
      debounce_ms  = DEBOUNCE_MS_RST;
      mode         = MODE_HWTEST;
      prev_home    = 1'b1;
      stable_home  = 1'b1;
      change_time  = '0;
      due_items.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TRIAL_SPEED:  trial_speed  = cfg_data[7:0];
          REG_HOMING_SPEED: homing_speed = cfg_data[7:0];
          REG_DEBOUNCE_MS:  debounce_ms  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        sequence_pass(in_tdata[31:0], in_tdata[32], in_tdata[33], in_tuser[0],
                      in_tuser[3:1], in_tdata[58:34]);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (due_items.size() == 0) begin
          $error("result with nothing due: kind %0d, byte %0h", out_tuser, out_tdata[7:0]);
          fail_count++;
        end else begin
          want = due_items.pop_front();
          check_field("kind", want.kind, out_tuser[2:0]);
          check_field("motor_byte", want.motor_byte, out_tdata[7:0]);
          check_field("sample_value", want.sample_value, $signed(out_tdata[32:8]));
          check_field("home_pressed", want.home_pressed, out_tdata[33]);
          check_field("end_pressed", want.end_pressed, out_tdata[34]);
          check_field("last", want.last, out_tlast);
        end
      end
    end
    results_due = due_items.size();
  end

endmodule

// File: sim/homing_trial_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// homing_trial_sequencer_unit_tb
// stimulus and verdict for the homing/trial sequencer
// ----------------------------------------------------------------------------
// A directed opening walks the hardware test commands, the ignored and unknown
// commands, homing across a time wrap with the debounce boundary, a pass that
// homes and stops at once, sampling and the end of a trial. Random homing and
// trial cycles then run under four register settings, extremes included, with
// bursty requests and a stalling receiver. The checker predicts and compares.
// ----------------------------------------------------------------------------
module homing_trial_sequencer_unit_tb;
  import htsu_pkg::*;

  // register index beyond the list, accepted and dropped by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // action codes with no meaning
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  // receiver stall patterns
  localparam int STALL_NONE  = 0;
  localparam int STALL_HALF  = 1;
  localparam int STALL_HEAVY = 2;

  localparam int RANDOM_PASSES = 220;
  localparam int PHASES        = 4;
  // passes with no result never reach the queue; the settle wait covers the front
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int results_due;
  int results_seen;

  int          passes_sent = 0;
  int          burst_left = 0;
  int          stall_pattern = STALL_NONE;
  int          stall_left = 0;
  int          debounce_set = 50;
  logic [31:0] pass_time = '0;

  always #5 clk = ~clk;

  homing_trial_sequencer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  htsu_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_due  (results_due),
    .results_seen (results_seen)
  );

  // receiver: switches between always ready, coin flip and mostly stalled
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pattern = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_left    = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    case (stall_pattern)
      STALL_NONE: out_tready <= 1'b1;
      STALL_HALF: out_tready <= 1'($urandom_range(0, 1));
      default:    out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // one pass request; bursts of random length, random gaps after each burst
  task automatic send_pass(input logic [31:0] now, input logic home,
                           input logic endl, input logic has_cmd,
                           input logic [2:0] act, input logic signed [24:0] load);
    int gap;
    in_tdata  <= {5'd0, load, endl, home, now};
    in_tuser  <= {act, has_cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    passes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 7);
    end
  endtask

  // stop sending, let every due result drain, then let the front settle
  task automatic quiesce();
    int waited;
    in_tvalid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (results_due != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three registers plus the spare index; junk in unused upper bits
  task automatic write_regs(input logic [7:0] trial, input logic [7:0] homing,
                            input logic [15:0] debounce);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_TRIAL_SPEED, REG_HOMING_SPEED, REG_DEBOUNCE_MS, REG_SPARE};
    val = '{{8'($urandom), trial}, {8'($urandom), homing}, debounce, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    debounce_set = debounce;
  endtask

  // mostly polls, some stray commands, rare emergency stops
  function automatic logic [2:0] host_action();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return ACT_ESTOP;
    if (r < 10) return ACT_POLL;
    return 3'($urandom_range(0, 7));
  endfunction

  initial begin
    int phase_start;
    int hold;
    int directed;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hardware test mode: silent pass, switch reports for all four levels
    send_pass(32'd0, 1'b1, 1'b1, 1'b0, ACT_START, '0);
    for (int c = 0; c < 4; c++) send_pass(32'd1, c[0], c[1], 1'b1, ACT_CHECK, '0);
    // commands that hardware test mode drops, unknown actions too
    send_pass(32'd2, 1'b1, 1'b1, 1'b1, ACT_POLL, 25'h0AB_CDEF);
    send_pass(32'd3, 1'b1, 1'b1, 1'b1, ACT_START, '0);
    send_pass(32'd4, 1'b0, 1'b0, 1'b1, ACT_SPARE_LO, '0);
    send_pass(32'd5, 1'b1, 1'b1, 1'b1, ACT_SPARE_HI, '1);
    // emergency stop keeps hardware test mode, end test moves to idle
    send_pass(32'd6, 1'b1, 1'b1, 1'b1, ACT_ESTOP, '0);
    send_pass(32'd7, 1'b1, 1'b1, 1'b1, ACT_END, '0);
    send_pass(32'd8, 1'b1, 1'b1, 1'b1, ACT_END, '0);
    // homing across the 32-bit time wrap: exactly the debounce time is not
    // enough, one more ms homes; an emergency stop in the same pass gives the
    // longest run of results
    send_pass(32'hFFFF_FFE0, 1'b1, 1'b1, 1'b1, ACT_START, '0);
    send_pass(32'hFFFF_FFF0, 1'b0, 1'b1, 1'b0, ACT_START, '0);
    send_pass(32'hFFFF_FFF0 + 32'd50, 1'b0, 1'b1, 1'b0, ACT_START, '0);
    send_pass(32'hFFFF_FFF0 + 32'd51, 1'b0, 1'b1, 1'b1, ACT_ESTOP, '0);
    // second homing with a bounce, homed and sampled in one pass
    send_pass(32'h100, 1'b1, 1'b1, 1'b1, ACT_START, '0);
    send_pass(32'h200, 1'b0, 1'b1, 1'b0, ACT_START, '0);
    send_pass(32'h210, 1'b1, 1'b1, 1'b0, ACT_START, '0);
    send_pass(32'h220, 1'b0, 1'b1, 1'b0, ACT_START, '0);
    send_pass(32'h220 + 32'd51, 1'b0, 1'b1, 1'b1, ACT_POLL, 25'h0FF_FFFF);
    send_pass(32'h300, 1'b1, 1'b1, 1'b1, ACT_POLL, 25'h100_0000);
    // end switch finishes the trial, the poll of that pass comes too late
    send_pass(32'h301, 1'b1, 1'b0, 1'b1, ACT_POLL, 25'h000_0001);
    send_pass(32'h302, 1'b1, 1'b1, 1'b1, ACT_ESTOP, '0);
    send_pass(32'h303, 1'b0, 1'b0, 1'b1, ACT_CHECK, '0);
    directed = passes_sent;

    for (int phase = 0; phase < PHASES; phase++) begin
      quiesce();
      case (phase)
        0: write_regs(8'd128, 8'd0, 16'd0);
        1: write_regs(8'd255, 8'd255, 16'hFFFF);
        2: write_regs(8'($urandom_range(128, 255)), 8'($urandom), 16'($urandom_range(0, 200)));
        default: write_regs(8'($urandom_range(128, 255)), 8'($urandom), 16'($urandom));
      endcase
      phase_start = passes_sent;
      while (passes_sent - phase_start < RANDOM_PASSES / PHASES) begin
        // sometimes home right across the time wrap
        if ($urandom_range(0, 5) == 0) begin
          pass_time = 32'hFFFF_FFFF - 32'($urandom_range(0, debounce_set + 3));
        end
        // start from idle, switch mostly released
        send_pass(pass_time, ($urandom_range(0, 7) != 0), 1'($urandom), 1'b1, ACT_START,
                  25'($urandom));
        repeat ($urandom_range(0, 3)) begin
          pass_time += 32'($urandom_range(0, 20));
          send_pass(pass_time, ($urandom_range(0, 5) != 0), 1'($urandom),
                    ($urandom_range(0, 3) == 0), host_action(), 25'($urandom));
        end
        // hold the switch pressed with steps from half to just over the full debounce
        // time, so the hold sometimes falls short; the odd bounce restarts it
        hold = $urandom_range(2, 6);
        repeat (hold) begin
          pass_time += 32'(debounce_set / 2 + $urandom_range(0, debounce_set / 2 + 2));
          send_pass(pass_time, ($urandom_range(0, 7) == 0), 1'($urandom),
                    ($urandom_range(0, 3) == 0), host_action(), 25'($urandom));
        end
        // trial running: polls with random loads, end switch released
        repeat ($urandom_range(1, 8)) begin
          pass_time += 32'($urandom_range(0, 1000));
          send_pass(pass_time, 1'($urandom), 1'b1, 1'($urandom), host_action(),
                    25'($urandom));
        end
        // end of travel
        pass_time += 32'($urandom_range(0, 1000));
        send_pass(pass_time, 1'($urandom), 1'b0, 1'($urandom), host_action(), 25'($urandom));
        // noise: anything at all
        repeat ($urandom_range(0, 2)) begin
          send_pass($urandom, 1'($urandom), 1'($urandom), 1'($urandom), 3'($urandom),
                    25'($urandom));
        end
      end
    end
    quiesce();

    if (results_due != 0) $error("%0d result requests never arrived", results_due);
    $display("covered %0d passes (%0d directed) under %0d register settings",
             passes_sent, directed, PHASES + 1);
    $display("compared %0d motor bytes and host reports", results_seen);
    if (fail_count == 0 && results_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
